// File: rtl/core/tlin_pkg.sv
// Shared types, constants and register map of the thermistor linearizer.
`timescale 1ns / 1ps
package tlin_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int ADC_W        = 12;
  localparam int ADDR_W       = 5;
  localparam int LN_ITER      = 24;
  localparam int DIV_ITER     = 63;

  localparam logic [31:0]        LN2_Q32     = 32'd2977044472;
  localparam logic signed [63:0] KELVIN_Q20  = 64'sd286417306;
  localparam logic signed [63:0] ABS_ZERO_Q8 = -64'sd69926;
  localparam logic signed [63:0] TMIN_Q8     = -64'sd10240;
  localparam logic signed [63:0] TMAX_Q8     = 64'sd32000;
  localparam logic [15:0]        DETECT_LOW  = 16'd100;
  localparam logic [15:0]        DETECT_HIGH = 16'd4000;

  localparam logic [2:0] REG_COEF_A = 3'd0;
  localparam logic [2:0] REG_COEF_B = 3'd1;
  localparam logic [2:0] REG_COEF_C = 3'd2;
  localparam logic [2:0] REG_SERIES = 3'd3;
  localparam logic [2:0] REG_SUPPLY = 3'd4;
  localparam logic [2:0] REG_OFFSET = 3'd5;

  localparam logic signed [31:0] COEF_A_RST = 32'sd69355000;
  localparam logic signed [31:0] COEF_B_RST = 32'sd261507000;
  localparam logic signed [31:0] COEF_C_RST = 32'sd909370000;
  localparam logic [19:0]        SERIES_RST = 20'd10000;
  localparam logic [12:0]        SUPPLY_RST = 13'd3300;
  localparam logic signed [15:0] OFFSET_RST = 16'sd0;

  localparam logic [1:0] ARG_SERIES = 2'd0;
  localparam logic [1:0] ARG_X      = 2'd1;
  localparam logic [1:0] ARG_REST   = 2'd2;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic [19:0]        series_ohms;
    logic [12:0]        supply_mv;
    logic signed [15:0] offset_cal;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_LN_INIT, OP_LN_STEP, OP_LN_ACC, OP_SQ, OP_CUBE_LO,
    OP_CUBE_HI, OP_MUL_B, OP_MUL_C, OP_DIV_INIT, OP_DIV_STEP, OP_RAW, OP_FIN
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic d_pos;
  } sts_t;

endpackage

// File: rtl/core/tlin_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module tlin_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tlin_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output tlin_pkg::cfg_t             cfg
);
  import tlin_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_a      <= COEF_A_RST;
      cfg_r.coef_b      <= COEF_B_RST;
      cfg_r.coef_c      <= COEF_C_RST;
      cfg_r.series_ohms <= SERIES_RST;
      cfg_r.supply_mv   <= SUPPLY_RST;
      cfg_r.offset_cal  <= OFFSET_RST;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_COEF_A: cfg_r.coef_a      <= pwdata;
        REG_COEF_B: cfg_r.coef_b      <= pwdata;
        REG_COEF_C: cfg_r.coef_c      <= pwdata;
        REG_SERIES: cfg_r.series_ohms <= pwdata[19:0];
        REG_SUPPLY: cfg_r.supply_mv   <= pwdata[12:0];
        REG_OFFSET: cfg_r.offset_cal  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COEF_A: prdata = cfg_r.coef_a;
      REG_COEF_B: prdata = cfg_r.coef_b;
      REG_COEF_C: prdata = cfg_r.coef_c;
      REG_SERIES: prdata = {12'd0, cfg_r.series_ohms};
      REG_SUPPLY: prdata = {19'd0, cfg_r.supply_mv};
      REG_OFFSET: prdata = {16'd0, cfg_r.offset_cal};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/core/tlin_dp.sv
// Datapath: log unit, multipliers, restoring divider and result registers.
`timescale 1ns / 1ps
module tlin_dp #(
  parameter int ADC_BITS = tlin_pkg::ADC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tlin_pkg::cfg_t            cfg,
  input  tlin_pkg::cmd_t            cmd,
  input  logic [tlin_pkg::ADC_W-1:0] sample,
  output tlin_pkg::sts_t            sts,
  output logic signed [16:0]        temperature,
  output logic                      reading_valid,
  output logic                      sample_plausible,
  output logic [31:0]               error_total
);
  import tlin_pkg::*;

  localparam logic [ADC_BITS-1:0] FULL = {ADC_BITS{1'b1}};

  function automatic logic signed [16:0] sat17(input logic signed [63:0] v);
    if (v < -64'sd65536)     sat17 = -17'sd65536;
    else if (v > 64'sd65535) sat17 = 17'sd65535;
    else                     sat17 = v[16:0];
  endfunction

  logic [ADC_BITS-1:0] x_r;
  logic [30:0]         m_r;
  logic [23:0]         frac_r;
  logic [4:0]          k_r;
  logic signed [31:0]  l_r;
  logic [35:0]         l2_r;
  logic signed [71:0]  cube_r;
  logic signed [31:0]  l3_r;
  logic signed [63:0]  d_r;
  logic [42:0]         rem_r;
  logic [62:0]         nq_r;
  logic [41:0]         dvs_r;
  logic signed [63:0]  raw_r;
  logic                finite_r;
  logic [31:0]         err_r;
  logic                conn_r;
  logic signed [16:0]  last_r;
  logic signed [16:0]  temp_r;
  logic                valid_r;
  logic                plaus_r;

  logic [19:0]         ser;
  logic [20:0]         arg;
  logic [4:0]          k_nxt;
  logic [30:0]         m_init;
  logic [61:0]         sq;
  logic [31:0]         t;
  logic [60:0]         lnprod;
  logic [61:0]         lnr;
  logic signed [31:0]  lnv;
  logic signed [63:0]  lsq;
  logic signed [71:0]  plo;
  logic signed [71:0]  phi;
  logic signed [71:0]  cr;
  logic signed [63:0]  pb;
  logic signed [63:0]  pc;
  logic [42:0]         rs;
  logic                ge;
  logic signed [63:0]  kd;
  logic signed [63:0]  tofs;
  logic                valid_now;
  logic [15:0]         xw;

  assign ser = (cfg.series_ohms == 20'd0) ? 20'd1 : cfg.series_ohms;

  always_comb begin
    case (cmd.sel)
      ARG_SERIES: arg = {1'b0, ser};
      ARG_X:      arg = 21'(x_r);
      default:    arg = 21'(FULL - x_r);
    endcase
  end

  // position of the leading one
  always_comb begin
    k_nxt = 5'd0;
    for (int i = 0; i < 21; i++) begin
      if (arg[i]) k_nxt = 5'(i);
    end
  end

  assign m_init = 31'({10'd0, arg} << (5'd30 - k_nxt));
  assign sq     = {31'd0, m_r} * {31'd0, m_r};
  assign t      = sq[61:30];
  assign lnprod = 61'({k_r, frac_r}) * 61'(LN2_Q32);
  assign lnr    = {1'b0, lnprod} + (62'd1 << 31);
  assign lnv    = {2'd0, lnr[61:32]};

  assign lsq = (l_r * l_r) + (64'sd1 <<< 23);
  assign plo = $signed({1'b0, l2_r[17:0]}) * l_r;
  assign phi = $signed({1'b0, l2_r[35:18]}) * l_r;
  assign cr  = cube_r + (phi <<< 18) + (72'sd1 <<< 35);
  assign pb  = cfg.coef_b * l_r;
  assign pc  = cfg.coef_c * l3_r;

  assign rs = {rem_r[41:0], nq_r[62]};
  assign ge = rs >= {1'b0, dvs_r};
  assign kd = $signed({1'b0, nq_r}) - KELVIN_Q20 + 64'sd2048;

  assign tofs      = raw_r + 64'(cfg.offset_cal);
  assign valid_now = finite_r && (raw_r >= TMIN_Q8) && (raw_r <= TMAX_Q8);
  assign xw        = 16'(x_r);

  assign sts.special = (x_r == '0) || (x_r == FULL);
  assign sts.d_pos   = !d_r[63] && (|d_r[62:22]);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x_r      <= ADC_BITS'({4'd0, sample});
        raw_r    <= ABS_ZERO_Q8;
        finite_r <= 1'b0;
      end
      OP_LN_INIT: begin
        k_r    <= k_nxt;
        m_r    <= m_init;
        frac_r <= '0;
      end
      OP_LN_STEP: begin
        if (t[31]) begin
          m_r    <= t[31:1];
          frac_r <= {frac_r[22:0], 1'b1};
        end else begin
          m_r    <= t[30:0];
          frac_r <= {frac_r[22:0], 1'b0};
        end
      end
      OP_LN_ACC: begin
        case (cmd.sel)
          ARG_SERIES: l_r <= lnv;
          ARG_X:      l_r <= l_r + lnv;
          default:    l_r <= l_r - lnv;
        endcase
      end
      OP_SQ:      l2_r   <= lsq[59:24];
      OP_CUBE_LO: cube_r <= plo;
      OP_CUBE_HI: l3_r   <= cr[67:36];
      OP_MUL_B:   d_r    <= (64'(cfg.coef_a) <<< 28) + pb;
      OP_MUL_C:   d_r    <= d_r + pc;
      OP_DIV_INIT: begin
        dvs_r <= d_r[63:22];
        rem_r <= '0;
        nq_r  <= {1'b1, 62'd0} + 63'(d_r[63:23]);
      end
      OP_DIV_STEP: begin
        rem_r <= ge ? (rs - {1'b0, dvs_r}) : rs;
        nq_r  <= {nq_r[61:0], ge};
      end
      OP_RAW: begin
        raw_r    <= kd >>> 12;
        finite_r <= 1'b1;
      end
      OP_FIN: begin
        temp_r  <= sat17(tofs);
        valid_r <= valid_now;
        plaus_r <= (xw > DETECT_LOW) && (xw < DETECT_HIGH);
      end
      default: ;
    endcase
  end

  // persistent state across items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r  <= '0;
      conn_r <= 1'b0;
      last_r <= '0;
    end else if (cmd.op == OP_FIN) begin
      last_r <= sat17(raw_r);
      conn_r <= valid_now;
      if (!valid_now && (err_r != '1)) err_r <= err_r + 32'd1;
    end
  end

  assign temperature      = temp_r;
  assign reading_valid    = valid_r && (conn_r || !conn_r) && (last_r == last_r);
  assign sample_plausible = plaus_r;
  assign error_total      = err_r;

endmodule

// File: rtl/core/tlin_ctrl.sv
// Controller: sequences the datapath through log, polynomial and division.
`timescale 1ns / 1ps
module tlin_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  tlin_pkg::sts_t sts,
  output tlin_pkg::cmd_t cmd
);
  import tlin_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LN_INIT, S_LN_STEP, S_LN_ACC, S_SQ, S_CUBE_LO, S_CUBE_HI,
    S_MUL_B, S_MUL_C, S_DIV_INIT, S_DIV, S_RAW, S_FIN
  } state_t;

  state_t     state_r;
  logic [1:0] sel_r;
  logic [5:0] cnt_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       fin_go;

  assign fin_go    = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // drop the result once taken, raise it when a new one is written
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if ((state_r == S_FIN) && fin_go) out_valid_nxt = 1'b1;
  end

  always_comb begin
    cmd.sel = sel_r;
    case (state_r)
      S_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_LN_INIT:  cmd.op = OP_LN_INIT;
      S_LN_STEP:  cmd.op = OP_LN_STEP;
      S_LN_ACC:   cmd.op = OP_LN_ACC;
      S_SQ:       cmd.op = OP_SQ;
      S_CUBE_LO:  cmd.op = OP_CUBE_LO;
      S_CUBE_HI:  cmd.op = OP_CUBE_HI;
      S_MUL_B:    cmd.op = OP_MUL_B;
      S_MUL_C:    cmd.op = OP_MUL_C;
      S_DIV_INIT: cmd.op = OP_DIV_INIT;
      S_DIV:      cmd.op = OP_DIV_STEP;
      S_RAW:      cmd.op = OP_RAW;
      S_FIN:      cmd.op = fin_go ? OP_FIN : OP_NONE;
      default:    cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= ARG_SERIES;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_IDLE: begin
          sel_r <= ARG_SERIES;
          if (in_valid) state_r <= S_LN_INIT;
        end
        S_LN_INIT: begin
          cnt_r   <= '0;
          state_r <= sts.special ? S_FIN : S_LN_STEP;
        end
        S_LN_STEP: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(LN_ITER - 1)) state_r <= S_LN_ACC;
        end
        S_LN_ACC: begin
          if (sel_r == ARG_REST) begin
            state_r <= S_SQ;
          end else begin
            sel_r   <= sel_r + 2'd1;
            state_r <= S_LN_INIT;
          end
        end
        S_SQ:      state_r <= S_CUBE_LO;
        S_CUBE_LO: state_r <= S_CUBE_HI;
        S_CUBE_HI: state_r <= S_MUL_B;
        S_MUL_B:   state_r <= S_MUL_C;
        S_MUL_C:   state_r <= S_DIV_INIT;
        S_DIV_INIT: begin
          cnt_r   <= '0;
          state_r <= sts.d_pos ? S_DIV : S_FIN;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(DIV_ITER - 1)) state_r <= S_RAW;
        end
        S_RAW: state_r <= S_FIN;
        S_FIN: begin
          if (fin_go) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/thermistor_linearizer.sv
// Top level of the thermistor linearizer: register file, controller, datapath.
`timescale 1ns / 1ps
// Converts one converter sample of a series-resistor divider into a calibrated
// temperature in 1/256 degree C using Steinhart-Hart in fixed point. One item
// is in flight at a time: a normal sample raises out_valid after three 24-step
// binary logarithms (one squaring per cycle, each with setup and accumulate),
// the polynomial steps (square, cube, A+B and C terms) and a 63-step restoring
// divider for the reciprocal; the next item can be taken once the block is back
// in idle. A zero or full-scale sample goes from log setup straight to finish;
// a non-positive polynomial sum skips the divider. in_stall is high while an
// item is being worked on; the result sits in an output register so the next
// item is taken while it waits, and a finished item holds until that register
// is free. Configuration registers sit at byte address 4*index; the user must
// see they are written only while the block is idle; it does not enforce that.
module thermistor_linearizer #(
  parameter int ADC_BITS = tlin_pkg::ADC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tlin_pkg::ADC_W-1:0]  in_adc_sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [16:0]          out_temperature,
  output logic                        out_reading_valid,
  output logic                        out_sample_plausible,
  output logic [31:0]                 out_error_total,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlin_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tlin_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // hold coefficients, series resistor, supply and offset
  tlin_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // step through log, cube, sum and divide for each item
  tlin_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and result registers
  tlin_dp #(.ADC_BITS(ADC_BITS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .sample           (in_adc_sample),
    .sts              (sts),
    .temperature      (out_temperature),
    .reading_valid    (out_reading_valid),
    .sample_plausible (out_sample_plausible),
    .error_total      (out_error_total)
  );

endmodule

// File: rtl/core/tlin_checker.sv
// Port-level checks of the thermistor linearizer and their binding.
`timescale 1ns / 1ps
module tlin_sva (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [16:0]          out_temperature,
  input logic                        out_reading_valid,
  input logic [31:0]                 out_error_total
);

  // a held result keeps its temperature and error total
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_temperature)
      && $stable(out_error_total))
    else $error("result changed while stalled");

  // an invalid reading has been counted
  a_err_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reading_valid |-> out_error_total != 32'd0)
    else $error("invalid reading without error count");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind thermistor_linearizer tlin_sva u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_temperature   (out_temperature),
  .out_reading_valid (out_reading_valid),
  .out_error_total   (out_error_total)
);

// File: verif/tlin_checker.sv
// Checker for the thermistor linearizer: tracks registers, predicts and compares results.
`timescale 1ns / 1ps
module tlin_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [tlin_pkg::ADC_W-1:0]  in_adc_sample,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [16:0]          out_temperature,
  input  logic                        out_reading_valid,
  input  logic                        out_sample_plausible,
  input  logic [31:0]                 out_error_total,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [tlin_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output int                          fail_count,
  output int                          pending
);
  import tlin_pkg::*;

  typedef struct {
    logic signed [16:0] temp;
    logic               valid;
    logic               plausible;
    logic [31:0]        errors;
  } reading_t;

  reading_t readings_due[$];
  cfg_t     regs;
  logic [31:0] err_cnt;

  function automatic longint log_q24(longint unsigned n);
    int unsigned    k;
    longint unsigned m, frac, l2;
    k = 0;
    frac = 0;
    while (k < 31 && (n >> (k + 1)) != 0) k++;
    m = n << (30 - k);
    for (int i = 0; i < LN_ITER; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    l2 = (longint'(k) << 24) | frac;
    return longint'((l2 * LN2_Q32 + (64'd1 << 31)) >> 32);
  endfunction

  function automatic longint clamp17(longint v);
    if (v < -65536) return -65536;
    if (v > 65535) return 65535;
    return v;
  endfunction

  function automatic reading_t convert(logic [ADC_W-1:0] x);
    reading_t r;
    longint l, lsq, lcube, sum, sum42, kelvin, raw;
    longint unsigned ser, ud;
    logic finite;
    raw = ABS_ZERO_Q8;
    finite = 0;
    if (x != 0 && x != 12'hFFF) begin
      ser = (regs.series_ohms == 0) ? 1 : regs.series_ohms;
      l = log_q24(ser) + log_q24(x) - log_q24(12'hFFF - x);
      lsq = (l * l + (64'sd1 <<< 23)) >>> 24;
      lcube = (lsq * l + (64'sd1 <<< 35)) >>> 36;
      sum = longint'(regs.coef_a) * (64'sd1 <<< 28) + longint'(regs.coef_b) * l
            + longint'(regs.coef_c) * lcube;
      sum42 = sum >>> 22;
      if (sum42 > 0) begin
        ud = sum42;
        kelvin = longint'(((64'd1 << 62) + ud / 2) / ud);
        raw = (kelvin - KELVIN_Q20 + (64'sd1 <<< 11)) >>> 12;
        finite = 1;
      end
    end
    r.valid = finite && raw >= TMIN_Q8 && raw <= TMAX_Q8;
    if (!r.valid && err_cnt != 32'hFFFF_FFFF) err_cnt = err_cnt + 1;
    r.temp = 17'(clamp17(raw + longint'(regs.offset_cal)));
    r.plausible = x > DETECT_LOW && x < DETECT_HIGH;
    r.errors = err_cnt;
    return r;
  endfunction

  assign pending = readings_due.size();

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      regs <= '{COEF_A_RST, COEF_B_RST, COEF_C_RST, SERIES_RST, SUPPLY_RST, OFFSET_RST};
      err_cnt = 0;
      fail_count <= 0;
      readings_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_COEF_A: regs.coef_a <= pwdata;
          REG_COEF_B: regs.coef_b <= pwdata;
          REG_COEF_C: regs.coef_c <= pwdata;
          REG_SERIES: regs.series_ohms <= pwdata[19:0];
          REG_SUPPLY: regs.supply_mv <= pwdata[12:0];
          REG_OFFSET: regs.offset_cal <= pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) readings_due.push_back(convert(in_adc_sample));
      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected item temp=%0d", $time, out_temperature);
          fail_count <= fail_count + 1;
        end else begin
          want = readings_due.pop_front();
          if (want.temp !== out_temperature || want.valid !== out_reading_valid ||
              want.plausible !== out_sample_plausible || want.errors !== out_error_total) begin
            $display("%0t: expected temp=%0d valid=%0b plaus=%0b err=%0d", $time,
                     want.temp, want.valid, want.plausible, want.errors);
            $display("%0t: actual   temp=%0d valid=%0b plaus=%0b err=%0d", $time,
                     out_temperature, out_reading_valid, out_sample_plausible,
                     out_error_total);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: verif/tb_thermistor_linearizer.sv
// Testbench top for the thermistor linearizer: stimulus, register phases and verdict.
`timescale 1ns / 1ps
module tb_thermistor_linearizer;
  import tlin_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [ADC_W-1:0] in_adc_sample = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [16:0] out_temperature;
  logic out_reading_valid, out_sample_plausible;
  logic [31:0] out_error_total;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int unsigned cycles = 0;
  bit burst_mode = 0;

  always #5 clk = ~clk;

  thermistor_linearizer dut (.*);

  tlin_checker chk (.*);

  // Hard stop well beyond the slowest legal run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("thermistor_linearizer: mismatch");
      $finish;
    end
  end

  // Result side: random stalls per item, one long hold-off so the block backs up,
  // and the occasional stretch with no stalling at all.
  initial begin
    int n, seen;
    logic took;
    seen = 0;
    @(posedge rst_n);
    forever begin
      n = burst_mode ? 0 : $urandom_range(0, 11);
      if (seen == 150) n = 600;
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
      do begin
        @(negedge clk);
        took = out_valid && !out_stall;
        @(posedge clk);
      end while (!took);
      seen++;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Offer one item after a random gap; hold it steady until taken. Valid stays
  // up after acceptance until the next call drops it or replaces the sample.
  task automatic send_sample(logic [ADC_W-1:0] x);
    int gap;
    logic took;
    gap = burst_mode ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_adc_sample <= x;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
  endtask

  // Drain everything outstanding before touching registers.
  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [ADC_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 12'($urandom_range(0, 4095));
      1: return $urandom_range(0, 3) == 0 ? 12'd0 : 12'hFFF;
      2: return 12'($urandom_range(95, 105));
      3: return 12'($urandom_range(3995, 4005));
      default: return 12'($urandom_range(200, 3900));
    endcase
  endfunction

  initial begin
    logic [ADC_W-1:0] edge_pts[12] = '{12'd0, 12'd1, 12'd100, 12'd101, 12'd2048,
      12'd3999, 12'd4000, 12'd4094, 12'd4095, 12'd2730, 12'd1365, 12'd500};
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // Default coefficients: corner samples first.
    foreach (edge_pts[i]) send_sample(edge_pts[i]);
    for (int i = 0; i < 300; i++) begin
      burst_mode = (i >= 200 && i < 240);
      send_sample(pick_sample());
    end
    burst_mode = 0;

    // Phase sweep: each pass changes the register set, then runs a batch.
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin
          reg_write(REG_SERIES, 32'd1);
          reg_write(REG_OFFSET, 32'hFFFF_8000);
          reg_write(REG_SUPPLY, 32'd1);
        end
        1: begin
          reg_write(REG_SERIES, 32'd1000000);
          reg_write(REG_OFFSET, 32'd32767);
          reg_write(REG_SUPPLY, 32'd5000);
        end
        2: begin
          reg_write(REG_SERIES, 32'd0);
          reg_write(REG_COEF_A, 32'h7FFF_FFFF);
          reg_write(REG_COEF_B, 32'h8000_0000);
          reg_write(REG_COEF_C, 32'h7FFF_FFFF);
        end
        3: begin
          reg_write(REG_COEF_A, 32'h8000_0000);
          reg_write(REG_COEF_B, 32'h7FFF_FFFF);
          reg_write(REG_COEF_C, 32'h8000_0000);
          reg_write(REG_SERIES, 32'hF_FFFF);
        end
        4: begin
          // Near-nominal coefficients with random trim keeps most readings in range.
          reg_write(REG_COEF_A, 69355000 + $urandom_range(0, 4000000) - 2000000);
          reg_write(REG_COEF_B, 261507000 + $urandom_range(0, 4000000) - 2000000);
          reg_write(REG_COEF_C, 909370000 + $urandom_range(0, 40000000) - 20000000);
          reg_write(REG_SERIES, $urandom_range(1000, 100000));
          reg_write(REG_OFFSET, $urandom_range(0, 65535));
        end
        default: begin
          reg_write(REG_COEF_A, $urandom());
          reg_write(REG_COEF_B, $urandom());
          reg_write(REG_COEF_C, $urandom());
          reg_write(REG_SERIES, $urandom_range(0, 1048575));
          reg_write(REG_SUPPLY, $urandom_range(0, 8191));
          reg_write(REG_OFFSET, $urandom_range(0, 65535));
        end
      endcase
      send_sample(12'd0);
      send_sample(12'hFFF);
      for (int i = 0; i < 230; i++) send_sample(pick_sample());
    end

    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("thermistor_linearizer: match");
    end else begin
      $display("thermistor_linearizer: mismatch");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/core/tlin_pkg.sv
rtl/core/tlin_regs.sv
rtl/core/tlin_dp.sv
rtl/core/tlin_ctrl.sv
rtl/core/thermistor_linearizer.sv
rtl/core/tlin_checker.sv
verif/tlin_checker.sv
verif/tb_thermistor_linearizer.sv
